// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge
`define RMLBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RMLBP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RMLBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RMLBP_ASSERT(label, prop, msg)
`define RMLBP_ASSERT_IMPL(label, ante, cons, msg)
`define RMLBP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rmlbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmlbp_pkg
// shared widths, command codes and pipeline structs of the rotation-minimum
// lbp histogram block
// ----------------------------------------------------------------------------
package rmlbp_pkg;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CODE_W     = 9;
  localparam int unsigned BIN_IDX_W  = 9;
  localparam int unsigned BIN_CNT_W  = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // histogram and window geometry
  localparam int unsigned NUM_BINS   = 512;
  localparam int unsigned WIN_N      = 9;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned DIM_RESET  = 256;

  // result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // nine window pixels, index 0 top-left to 8 bottom-right
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  // per-transaction control carried down the pipeline
  typedef struct packed {
    logic                 valid;
    cmd_e                 cmd;
    logic                 emit;
    logic                 last;
    logic [BIN_IDX_W-1:0] bin;
  } ctl_t;

  // one result transaction
  typedef struct packed {
    logic                 code_valid;
    logic [CODE_W-1:0]    lbp_code;
    logic                 image_done;
    logic                 count_valid;
    logic [BIN_CNT_W-1:0] bin_count;
  } res_t;

  // histogram status toward the top level
  typedef struct packed {
    logic busy;
    logic drop;
  } hist_stat_t;

endpackage

// ===== hw/rtl/rmlbp_if.sv =====
// ----------------------------------------------------------------------------
// rmlbp stream interfaces
// valid/ready channels for commands in and results out
// ----------------------------------------------------------------------------

// command channel
interface rmlbp_in_if;
  logic                              valid;
  logic                              ready;
  logic [rmlbp_pkg::CMD_W-1:0]       cmd;
  logic [rmlbp_pkg::PIX_W-1:0]       pixel;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]   bin_index;

  modport source (output valid, cmd, pixel, bin_index, input ready);
  modport sink   (input valid, cmd, pixel, bin_index, output ready);
endinterface

// result channel
interface rmlbp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              code_valid;
  logic [rmlbp_pkg::CODE_W-1:0]      lbp_code;
  logic                              image_done;
  logic                              count_valid;
  logic [rmlbp_pkg::BIN_CNT_W-1:0]   bin_count;

  modport source (output valid, code_valid, lbp_code, image_done, count_valid, bin_count,
                  input ready);
  modport sink   (input valid, code_valid, lbp_code, image_done, count_valid, bin_count,
                  output ready);
endinterface

// ===== hw/rtl/rmlbp_window.sv =====
// ----------------------------------------------------------------------------
// rmlbp_window
// two line stores and the 3x3 window; registers the nine pixels and their sum
// ----------------------------------------------------------------------------
module rmlbp_window #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmlbp_pkg::ctl_t                   ctl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      col_i,
  input  logic [rmlbp_pkg::PIX_W-1:0]       pixel_i,
  output rmlbp_pkg::ctl_t                   ctl_o,
  output rmlbp_pkg::win_t                   win_o,
  output logic [rmlbp_pkg::SUM_W-1:0]       sum_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WC_N = 6;

  logic [rmlbp_pkg::PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [rmlbp_pkg::PIX_W-1:0] mid_mem [MAX_WIDTH];

  logic                                   push_acc;
  rmlbp_pkg::ctl_t                        ctl_s1_q;
  logic [CW-1:0]                          col_s1_q;
  logic [rmlbp_pkg::PIX_W-1:0]            pix_s1_q;
  logic [rmlbp_pkg::PIX_W-1:0]            top_rd_q;
  logic [rmlbp_pkg::PIX_W-1:0]            mid_rd_q;
  logic [WC_N-1:0][rmlbp_pkg::PIX_W-1:0]  wc_q;
  logic                                   s1_push;
  logic                                   s1_clear;
  rmlbp_pkg::win_t                        win_d;
  logic [rmlbp_pkg::SUM_W-1:0]            sum_d;
  rmlbp_pkg::ctl_t                        ctl_s2_q;
  rmlbp_pkg::win_t                        win_s2_q;
  logic [rmlbp_pkg::SUM_W-1:0]            sum_s2_q;

  assign push_acc = ctl_i.valid && (ctl_i.cmd == rmlbp_pkg::CMD_PUSH);
  assign s1_push  = ctl_s1_q.valid && (ctl_s1_q.cmd == rmlbp_pkg::CMD_PUSH);
  assign s1_clear = ctl_s1_q.valid && (ctl_s1_q.cmd == rmlbp_pkg::CMD_CLEAR);

  // middle row store: read old pixel and store the new one at the same column
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      mid_rd_q       <= mid_mem[col_i];
      mid_mem[col_i] <= pixel_i;
    end
  end

  // top row store read at accept
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      top_rd_q <= top_mem[col_i];
    end
  end

  // top row store takes the old middle pixel in the cycle after accept
  always_ff @(posedge clk_i) begin
    if (s1_push) begin
      top_mem[col_s1_q] <= mid_rd_q;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s1_q <= '0;
    end else begin
      ctl_s1_q <= ctl_i;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    col_s1_q <= col_i;
    pix_s1_q <= pixel_i;
  end

  // window assembly and pixel sum
  always_comb begin
    win_d[0] = wc_q[0];
    win_d[3] = wc_q[1];
    win_d[6] = wc_q[2];
    win_d[1] = wc_q[3];
    win_d[4] = wc_q[4];
    win_d[7] = wc_q[5];
    win_d[2] = top_rd_q;
    win_d[5] = mid_rd_q;
    win_d[8] = pix_s1_q;
    sum_d = '0;
    for (int k = 0; k < rmlbp_pkg::WIN_N; k++) begin
      sum_d = sum_d + rmlbp_pkg::SUM_W'(win_d[k]);
    end
  end

  // previous two columns shift on every push and are zeroed by a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= '0;
    end else if (s1_clear) begin
      wc_q <= '0;
    end else if (s1_push) begin
      wc_q[0] <= wc_q[3];
      wc_q[1] <= wc_q[4];
      wc_q[2] <= wc_q[5];
      wc_q[3] <= top_rd_q;
      wc_q[4] <= mid_rd_q;
      wc_q[5] <= pix_s1_q;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s2_q <= '0;
    end else begin
      ctl_s2_q <= ctl_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_s2_q <= win_d;
    sum_s2_q <= sum_d;
  end

  assign ctl_o = ctl_s2_q;
  assign win_o = win_s2_q;
  assign sum_o = sum_s2_q;

endmodule

// ===== hw/rtl/rmlbp_code.sv =====
// ----------------------------------------------------------------------------
// rmlbp_code
// mean threshold pattern, then minimum over the nine circular rotations
// ----------------------------------------------------------------------------
module rmlbp_code (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmlbp_pkg::ctl_t                   ctl_i,
  input  rmlbp_pkg::win_t                   win_i,
  input  logic [rmlbp_pkg::SUM_W-1:0]       sum_i,
  output rmlbp_pkg::ctl_t                   ctl_o,
  output logic [rmlbp_pkg::BIN_IDX_W-1:0]   addr_o
);

  logic [rmlbp_pkg::CODE_W-1:0]     pat_d;
  logic [rmlbp_pkg::SUM_W-1:0]      prod;
  rmlbp_pkg::ctl_t                  ctl_s3_q;
  logic [rmlbp_pkg::CODE_W-1:0]     pat_s3_q;
  logic [rmlbp_pkg::CODE_W-1:0]     best;
  logic [rmlbp_pkg::CODE_W-1:0]     rot;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  addr_d;
  rmlbp_pkg::ctl_t                  ctl_s4_q;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  addr_s4_q;

  // bit 8-k set where 9*p[k] exceeds the window sum
  always_comb begin
    pat_d = '0;
    prod  = '0;
    for (int k = 0; k < rmlbp_pkg::WIN_N; k++) begin
      prod = (rmlbp_pkg::SUM_W'(win_i[k]) << 3) + rmlbp_pkg::SUM_W'(win_i[k]);
      pat_d[rmlbp_pkg::CODE_W-1-k] = (prod > sum_i);
    end
  end

  // stage 3 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s3_q <= '0;
    end else begin
      ctl_s3_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_s3_q <= pat_d;
  end

  // smallest rotate-right of the pattern
  always_comb begin
    best = pat_s3_q;
    rot  = pat_s3_q;
    for (int j = 1; j < rmlbp_pkg::CODE_W; j++) begin
      rot = rmlbp_pkg::CODE_W'({pat_s3_q, pat_s3_q} >> j);
      if (rot < best) begin
        best = rot;
      end
    end
  end

  // bin reads use the requested index, pushes the code
  assign addr_d = (ctl_s3_q.cmd == rmlbp_pkg::CMD_READ) ? ctl_s3_q.bin : best;

  // stage 4 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s4_q <= '0;
    end else begin
      ctl_s4_q <= ctl_s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_s4_q <= addr_d;
  end

  assign ctl_o  = ctl_s4_q;
  assign addr_o = addr_s4_q;

endmodule

// ===== hw/rtl/rmlbp_hist.sv =====
// ----------------------------------------------------------------------------
// rmlbp_hist
// 512-bin histogram memory: read, saturating increment with write forwarding,
// bin read-back and the clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmlbp_hist #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmlbp_pkg::ctl_t                   ctl_i,
  input  logic [rmlbp_pkg::BIN_IDX_W-1:0]   addr_i,
  output logic                              res_valid_o,
  output rmlbp_pkg::res_t                   res_o,
  output rmlbp_pkg::hist_stat_t             stat_o
);

  logic [COUNT_BITS-1:0] hist_mem [rmlbp_pkg::NUM_BINS];

  logic [COUNT_BITS-1:0]            rd_q;
  rmlbp_pkg::ctl_t                  ctl_s5_q;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  addr_s5_q;
  logic                             fwd_vld_q;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  fwd_addr_q;
  logic [COUNT_BITS-1:0]            fwd_data_q;
  logic                             clr_busy_q;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  clr_addr_q;
  logic [COUNT_BITS-1:0]            cnt;
  logic [COUNT_BITS-1:0]            cnt_inc;
  logic                             push_hit;
  logic                             read_hit;
  logic                             s5_clear;
  logic                             we;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]  waddr;
  logic [COUNT_BITS-1:0]            wdata;

  // registered read, one per cycle
  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[addr_i];
  end

  // stage 5 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s5_q <= '0;
    end else begin
      ctl_s5_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_s5_q <= addr_i;
  end

  assign push_hit = ctl_s5_q.valid && (ctl_s5_q.cmd == rmlbp_pkg::CMD_PUSH) && ctl_s5_q.emit;
  assign read_hit = ctl_s5_q.valid && (ctl_s5_q.cmd == rmlbp_pkg::CMD_READ);
  assign s5_clear = ctl_s5_q.valid && (ctl_s5_q.cmd == rmlbp_pkg::CMD_CLEAR);

  // take the write of the previous cycle if it hit the same bin
  assign cnt     = (fwd_vld_q && (fwd_addr_q == addr_s5_q)) ? fwd_data_q : rd_q;
  assign cnt_inc = (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);

  // single write port shared by increment and clearing pass
  always_comb begin
    we    = 1'b0;
    waddr = addr_s5_q;
    wdata = cnt_inc;
    if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else if (push_hit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_mem[waddr] <= wdata;
    end
  end

  // last write, for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= waddr;
    fwd_data_q <= wdata;
  end

  // clearing pass after reset and after a clear transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + rmlbp_pkg::BIN_IDX_W'(1);
      if (clr_addr_q == rmlbp_pkg::BIN_IDX_W'(rmlbp_pkg::NUM_BINS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end else if (s5_clear) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end
  end

  // result build
  always_comb begin
    res_o             = '0;
    res_o.code_valid  = push_hit;
    res_o.lbp_code    = push_hit ? addr_s5_q : '0;
    res_o.image_done  = push_hit && ctl_s5_q.last;
    res_o.count_valid = read_hit;
    res_o.bin_count   = read_hit ? rmlbp_pkg::BIN_CNT_W'(cnt) : '0;
  end

  assign res_valid_o = push_hit || read_hit;
  assign stat_o.busy = clr_busy_q;
  assign stat_o.drop = ctl_s5_q.valid && !(push_hit || read_hit);

  // checks
  `RMLBP_ASSERT_IMPL(a_no_item_during_clear, clr_busy_q, !ctl_s5_q.valid,
                     "transaction reached the histogram during the clearing pass")
  `RMLBP_ASSERT_NEXT(a_clear_starts_pass, s5_clear && !clr_busy_q, clr_busy_q,
                     "clear transaction did not start the clearing pass")

endmodule

// ===== hw/rtl/rmlbp_fifo.sv =====
// ----------------------------------------------------------------------------
// rmlbp_fifo
// result queue between the pipeline and the output channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmlbp_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_valid_i,
  input  rmlbp_pkg::res_t                   wr_data_i,
  input  logic                              rd_ready_i,
  output logic                              rd_valid_o,
  output rmlbp_pkg::res_t                   rd_data_o
);

  rmlbp_pkg::res_t                     mem_q [rmlbp_pkg::FIFO_DEPTH];
  logic [rmlbp_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
  logic [rmlbp_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
  logic [rmlbp_pkg::FIFO_CNT_W-1:0]    cnt_q;
  logic                                pop;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign pop        = rd_valid_o && rd_ready_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + rmlbp_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + rmlbp_pkg::FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + rmlbp_pkg::FIFO_CNT_W'(wr_valid_i) - rmlbp_pkg::FIFO_CNT_W'(pop);
    end
  end

  // checks
  `RMLBP_ASSERT_IMPL(a_fifo_no_overflow, wr_valid_i,
                     cnt_q != rmlbp_pkg::FIFO_CNT_W'(rmlbp_pkg::FIFO_DEPTH),
                     "result written into a full queue")

endmodule

// ===== hw/rtl/rotation_min_lbp_histogram_top.sv =====
// ----------------------------------------------------------------------------
// rotation_min_lbp_histogram_top
// rotation-minimum 3x3 local binary pattern codes and their 512-bin histogram
//
//   channel   dir  handshake             payload
//   in_i      in   valid/ready           cmd, pixel, bin_index
//   out_o     out  valid/ready           code_valid, lbp_code, image_done,
//                                        count_valid, bin_count
//   cfg       in   cfg_we_i, no wait     cfg_idx_i, cfg_data_i
//
// one transaction per cycle while in_i.ready is high; after acceptance a
// result reaches the output queue through the line store read, sum,
// threshold, rotation minimum and histogram read-modify-write stages
// the output queue holds 8 results; in_i.ready drops once accepted
// transactions in flight plus queued results reach 8
// the histogram clearing pass zeroes all 512 bins after reset and after each
// clear transaction; no transaction is accepted meanwhile
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_min_lbp_histogram_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rmlbp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rmlbp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  rmlbp_in_if.sink                           in_i,
  rmlbp_out_if.source                        out_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCW = (WB > rmlbp_pkg::DIM_W) ? WB : rmlbp_pkg::DIM_W;
  localparam int unsigned HCW = (HB > rmlbp_pkg::DIM_W) ? HB : rmlbp_pkg::DIM_W;

  logic [rmlbp_pkg::DIM_W-1:0]        width_q;
  logic [rmlbp_pkg::DIM_W-1:0]        height_q;
  logic [WCW-1:0]                     w_eff;
  logic [HCW-1:0]                     h_eff;
  logic [CW-1:0]                      col_q;
  logic [RW-1:0]                      row_q;
  logic                               col_end;
  logic                               row_end;
  logic                               acc;
  rmlbp_pkg::cmd_e                    in_cmd;
  rmlbp_pkg::ctl_t                    ctl_in;
  logic                               clr_pend_q;
  logic [rmlbp_pkg::FIFO_CNT_W-1:0]   occ_q;
  logic                               pop;
  rmlbp_pkg::ctl_t                    ctl_s2;
  rmlbp_pkg::win_t                    win_s2;
  logic [rmlbp_pkg::SUM_W-1:0]        sum_s2;
  rmlbp_pkg::ctl_t                    ctl_s4;
  logic [rmlbp_pkg::BIN_IDX_W-1:0]    addr_s4;
  logic                               res_valid;
  rmlbp_pkg::res_t                    res;
  rmlbp_pkg::hist_stat_t              hist_stat;
  logic                               q_valid;
  rmlbp_pkg::res_t                    q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rmlbp_pkg::DIM_W'(rmlbp_pkg::DIM_RESET);
      height_q <= rmlbp_pkg::DIM_W'(rmlbp_pkg::DIM_RESET);
    end else if (cfg_we_i) begin
      case (rmlbp_pkg::cfg_reg_e'(cfg_idx_i))
        rmlbp_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        rmlbp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimensions clamped to the supported range
  always_comb begin
    w_eff = WCW'(width_q);
    if (width_q < rmlbp_pkg::DIM_W'(rmlbp_pkg::MIN_DIM)) begin
      w_eff = WCW'(rmlbp_pkg::MIN_DIM);
    end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end
    h_eff = HCW'(height_q);
    if (height_q < rmlbp_pkg::DIM_W'(rmlbp_pkg::MIN_DIM)) begin
      h_eff = HCW'(rmlbp_pkg::MIN_DIM);
    end else if (HCW'(height_q) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end
  end

  // input handshake
  assign in_i.ready = !clr_pend_q && !hist_stat.busy &&
                      (occ_q < rmlbp_pkg::FIFO_CNT_W'(rmlbp_pkg::FIFO_DEPTH));
  assign acc        = in_i.valid && in_i.ready;
  assign in_cmd     = rmlbp_pkg::cmd_e'(in_i.cmd);

  // raster position
  assign col_end = (WCW'(col_q) + WCW'(1)) >= w_eff;
  assign row_end = (HCW'(row_q) + HCW'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc && (in_cmd == rmlbp_pkg::CMD_CLEAR)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc && (in_cmd == rmlbp_pkg::CMD_PUSH)) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // control entering the pipeline
  always_comb begin
    ctl_in.valid = acc;
    ctl_in.cmd   = in_cmd;
    ctl_in.emit  = (col_q >= CW'(2)) && (row_q >= RW'(2));
    ctl_in.last  = col_end && row_end;
    ctl_in.bin   = in_i.bin_index;
  end

  // hold input from a clear until its clearing pass has begun
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_pend_q <= 1'b0;
    end else if (acc && (in_cmd == rmlbp_pkg::CMD_CLEAR)) begin
      clr_pend_q <= 1'b1;
    end else if (hist_stat.busy) begin
      clr_pend_q <= 1'b0;
    end
  end

  // transactions in flight plus results queued
  assign pop = q_valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + rmlbp_pkg::FIFO_CNT_W'(acc)
                     - rmlbp_pkg::FIFO_CNT_W'(hist_stat.drop)
                     - rmlbp_pkg::FIFO_CNT_W'(pop);
    end
  end

  rmlbp_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .col_i   (col_q),
    .pixel_i (in_i.pixel),
    .ctl_o   (ctl_s2),
    .win_o   (win_s2),
    .sum_o   (sum_s2)
  );

  rmlbp_code u_code (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_s2),
    .win_i  (win_s2),
    .sum_i  (sum_s2),
    .ctl_o  (ctl_s4),
    .addr_o (addr_s4)
  );

  rmlbp_hist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_s4),
    .addr_i      (addr_s4),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (hist_stat)
  );

  rmlbp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_data_i  (res),
    .rd_ready_i (out_o.ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data)
  );

  // output channel
  assign out_o.valid       = q_valid;
  assign out_o.code_valid  = q_data.code_valid;
  assign out_o.lbp_code    = q_data.lbp_code;
  assign out_o.image_done  = q_data.image_done;
  assign out_o.count_valid = q_data.count_valid;
  assign out_o.bin_count   = q_data.bin_count;

  // checks
  `RMLBP_ASSERT(a_occ_bounded, occ_q <= rmlbp_pkg::FIFO_CNT_W'(rmlbp_pkg::FIFO_DEPTH),
                "in-flight count exceeds queue depth")
  `RMLBP_ASSERT_NEXT(a_clear_blocks_input, acc && (in_cmd == rmlbp_pkg::CMD_CLEAR),
                     !in_i.ready, "input accepted right after a clear transaction")

endmodule
